[hw/rtl/hblc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hblc_pkg: shared definitions for the hashed bucket LRU id cache
// Field widths, operation codes, hash constants and parameter defaults.
// ----------------------------------------------------------------------------
package hblc_pkg;

	localparam int DEF_SETS = 64;
	localparam int DEF_WAYS = 16;

	localparam int ID_W  = 64;
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;
	localparam int BC_W  = 7;

	localparam int IN_DATA_W  = ID_W + VAL_W;
	localparam int OUT_DATA_W = VAL_W + 3 * CNT_W;
	localparam int OUT_USER_W = 2;

	localparam logic [BC_W-1:0] BC_RESET = 7'd64;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam int HASH_STEPS = 8;
	localparam int MOD_STEPS  = 32;

endpackage

[hw/rtl/hblc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hblc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hblc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/hblc_hash_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hblc_hash_mod: iterative set index unit
// Folds the id into a 32-bit Bernstein hash one byte per cycle, then reduces
// it modulo the bucket count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hblc_hash_mod #(
	parameter int SETS = hblc_pkg::DEF_SETS,
	parameter int SW   = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [hblc_pkg::ID_W-1:0] id,
	input  logic [hblc_pkg::BC_W-1:0] divisor,
	output logic                      done,
	output logic [SW-1:0]             set
);

	import hblc_pkg::*;

	localparam int TOTAL = HASH_STEPS + MOD_STEPS;
	localparam int CW    = $clog2(TOTAL);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [31:0]     h_q;
	logic [ID_W-1:0] idb_q;
	logic [BC_W-1:0] rem_q;
	logic [BC_W-1:0] div_q;
	logic [BC_W:0]   trial;
	logic [BC_W:0]   trial_sub;

	assign trial     = {rem_q, h_q[31]};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CW'(cnt_q + 1'b1);
				if (cnt_q == CW'(TOTAL - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q   <= HASH_SEED;
			idb_q <= id;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (cnt_q < CW'(HASH_STEPS)) begin
				h_q   <= (h_q << 5) + h_q + {24'd0, idb_q[7:0]};
				idb_q <= idb_q >> 8;
			end else begin
				h_q   <= h_q << 1;
				rem_q <= (trial >= {1'b0, div_q}) ? BC_W'(trial_sub) : BC_W'(trial);
			end
		end
	end

	assign done = done_q;
	assign set  = SW'(rem_q);

endmodule

[hw/rtl/hashed_bucket_lru_id_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_bucket_lru_id_cache: set-associative LRU id cache, hashed sets
// Looks up 64-bit ids in SETS sets of WAYS ways with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
// Input beats arrive on the s_ channel. s_tuser selects a lookup or a clear
// of the statistics counters; s_tdata carries the id and the fill value used
// on a miss. Every input beat yields exactly one m_ beat with the hit and
// eviction flags, the value now held for the id and the three counters.
// The cfg channel writes the bucket count; it is always ready and should be
// written only while no beat is in flight.
// A lookup runs through these steps from accept to result: the set index unit
// hashes the id and takes its remainder, then hands the set over; a read pass
// over the set's ways searches tags and ranks; a decision step follows; a
// read-modify-write pass updates recency; and the output register is loaded.
// A clear beat goes straight from accept to the output load, once it is free.
// One beat is worked on at a time; the next beat is accepted in the cycle
// after the result is loaded.
// After reset a clearing pass over all SETS*WAYS lines initializes valid
// bits and ranks; s_tready stays low meanwhile.
// The result sits in an output register, so the next beat is accepted while
// the receiver stalls; a finished result waits there until m_tready.
// ----------------------------------------------------------------------------
module hashed_bucket_lru_id_cache #(
	parameter int SETS = hblc_pkg::DEF_SETS,
	parameter int WAYS = hblc_pkg::DEF_WAYS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hblc_pkg::BC_W-1:0]       cfg_data,      // bucket_count
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hblc_pkg::IN_DATA_W-1:0]  s_tdata,       // lookup_id, fill_value
	input  logic                            s_tuser,       // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hblc_pkg::OUT_DATA_W-1:0] m_tdata,       // value, hit_count,
	                                                       // miss_count, evict_count
	output logic [hblc_pkg::OUT_USER_W-1:0] m_tuser        // hit, evicted
);

	import hblc_pkg::*;

	localparam int LINES = SETS * WAYS;
	localparam int AW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WW    = $clog2(WAYS + 1);
	localparam int MW    = RW + 1;
	localparam int TW    = ID_W + VAL_W;

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_HASH   = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_UPD    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]       state_q;
	logic [BC_W-1:0]  bucket_count_q;
	logic [BC_W-1:0]  divisor;
	logic             op_q;
	logic [ID_W-1:0]  id_q;
	logic [VAL_W-1:0] fill_q;
	logic [AW-1:0]    base_q;
	logic [AW-1:0]    clr_q;
	logic [WW-1:0]    cw_q;
	logic [WW-1:0]    w_q;
	logic             rv_s1;
	logic [WW-1:0]    rw_s1;
	logic             found_q;
	logic [WW-1:0]    fway_q;
	logic [RW-1:0]    frank_q;
	logic [VAL_W-1:0] fdata_q;
	logic [WW-1:0]    vway_q;
	logic             vvalid_q;
	logic [WW-1:0]    tgt_q;
	logic [RW-1:0]    old_q;
	logic             m_valid_q;
	logic             hit_out_q;
	logic             evict_out_q;
	logic [VAL_W-1:0] value_out_q;
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] evicts_q;

	logic             accept;
	logic             hm_start;
	logic             hm_done;
	logic [SW-1:0]    hm_set;
	logic             rd_issue;
	logic             out_free;
	logic             fin_load;

	logic             td_we;
	logic [AW-1:0]    td_waddr;
	logic [TW-1:0]    td_wdata;
	logic [TW-1:0]    td_rdata;
	logic             meta_we;
	logic [AW-1:0]    meta_waddr;
	logic [MW-1:0]    meta_wdata;
	logic [MW-1:0]    meta_rdata;
	logic [AW-1:0]    raddr;
	logic             rd_valid;
	logic [RW-1:0]    rd_rank;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign hm_start  = accept && (s_tuser == OP_LOOKUP);
	assign rd_issue  = ((state_q == ST_SCAN) || (state_q == ST_UPD)) && (w_q < WW'(WAYS));
	assign out_free  = !m_valid_q || m_tready;
	assign fin_load  = (state_q == ST_FIN) && out_free;
	assign raddr     = AW'(base_q + AW'(w_q));
	assign rd_valid  = meta_rdata[RW];
	assign rd_rank   = meta_rdata[RW-1:0];

	always_comb begin
		if (bucket_count_q == '0) begin
			divisor = BC_W'(1);
		end else if (32'(bucket_count_q) > SETS) begin
			divisor = BC_W'(SETS);
		end else begin
			divisor = bucket_count_q;
		end
	end

	hblc_hash_mod #(
		.SETS (SETS)
	) u_hash_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hm_start),
		.id      (s_tdata[ID_W-1:0]),
		.divisor (divisor),
		.done    (hm_done),
		.set     (hm_set)
	);

	assign td_we    = (state_q == ST_DECIDE) && !found_q;
	assign td_waddr = AW'(base_q + AW'(vway_q));
	assign td_wdata = {id_q, fill_q};

	hblc_ram #(
		.WIDTH (TW),
		.DEPTH (LINES)
	) u_tag_ram (
		.clk   (clk),
		.we    (td_we),
		.waddr (td_waddr),
		.wdata (td_wdata),
		.raddr (raddr),
		.rdata (td_rdata)
	);

	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = clr_q;
		meta_wdata = {1'b0, RW'(cw_q)};
		if (state_q == ST_CLR) begin
			meta_we = 1'b1;
		end else if ((state_q == ST_UPD) && rv_s1) begin
			meta_we    = 1'b1;
			meta_waddr = AW'(base_q + AW'(rw_s1));
			if (rw_s1 == tgt_q) begin
				meta_wdata = {1'b1, RW'(0)};
			end else if (rd_rank < old_q) begin
				meta_wdata = {rd_valid, RW'(rd_rank + 1'b1)};
			end else begin
				meta_wdata = meta_rdata;
			end
		end
	end

	hblc_ram #(
		.WIDTH (MW),
		.DEPTH (LINES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (raddr),
		.rdata (meta_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bucket_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			cw_q      <= '0;
			w_q       <= '0;
			rv_s1     <= 1'b0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
			hits_q    <= '0;
			misses_q  <= '0;
			evicts_q  <= '0;
		end else begin
			rv_s1 <= rd_issue;
			if (rd_issue) begin
				w_q <= WW'(w_q + 1'b1);
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= AW'(clr_q + 1'b1);
					cw_q  <= (cw_q == WW'(WAYS - 1)) ? '0 : WW'(cw_q + 1'b1);
					if (clr_q == AW'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == OP_CLEAR) ? ST_FIN : ST_HASH;
					end
				end
				ST_HASH: begin
					if (hm_done) begin
						w_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rv_s1 && rd_valid && (td_rdata[TW-1:VAL_W] == id_q)) begin
						found_q <= 1'b1;
					end
					if ((w_q == WW'(WAYS)) && !rv_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					w_q     <= '0;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if ((w_q == WW'(WAYS)) && !rv_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
						if (op_q == OP_CLEAR) begin
							hits_q   <= '0;
							misses_q <= '0;
							evicts_q <= '0;
						end else if (found_q) begin
							hits_q <= CNT_W'(hits_q + 1'b1);
						end else begin
							misses_q <= CNT_W'(misses_q + 1'b1);
							if (vvalid_q) begin
								evicts_q <= CNT_W'(evicts_q + 1'b1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rw_s1 <= w_q;
		if (accept) begin
			op_q   <= s_tuser;
			id_q   <= s_tdata[ID_W-1:0];
			fill_q <= s_tdata[IN_DATA_W-1:ID_W];
		end
		if ((state_q == ST_HASH) && hm_done) begin
			base_q <= AW'(AW'(hm_set) * AW'(WAYS));
		end
		if ((state_q == ST_SCAN) && rv_s1) begin
			if (rd_valid && (td_rdata[TW-1:VAL_W] == id_q)) begin
				fway_q  <= rw_s1;
				frank_q <= rd_rank;
				fdata_q <= td_rdata[VAL_W-1:0];
			end
			if (rd_rank == RW'(WAYS - 1)) begin
				vway_q   <= rw_s1;
				vvalid_q <= rd_valid;
			end
		end
		if (state_q == ST_DECIDE) begin
			tgt_q <= found_q ? fway_q : vway_q;
			old_q <= found_q ? frank_q : RW'(WAYS - 1);
		end
		if (fin_load) begin
			hit_out_q   <= (op_q == OP_LOOKUP) && found_q;
			evict_out_q <= (op_q == OP_LOOKUP) && !found_q && vvalid_q;
			if (op_q == OP_CLEAR) begin
				value_out_q <= '0;
			end else begin
				value_out_q <= found_q ? fdata_q : fill_q;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {evicts_q, misses_q, hits_q, value_out_q};
	assign m_tuser  = {evict_out_q, hit_out_q};

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && (op_q == OP_CLEAR)) |=> (m_tdata[OUT_DATA_W-1:VAL_W] == '0))
		else $error("clear beat did not zero the counters");

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && (op_q == OP_LOOKUP) && found_q)
		|=> (m_tdata[VAL_W+CNT_W-1:VAL_W] == CNT_W'($past(hits_q) + 1'b1)))
		else $error("hit did not advance the hit counter");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("hit and eviction flagged together");

	a_hash_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		hm_done |-> (state_q == ST_HASH))
		else $error("set index finished outside the hash wait");

endmodule
